@@ rtl/rau_pkg.sv @@
// shared types and constants of the rational arithmetic unit
package rau_pkg;

  localparam int unsigned DataW    = 32;
  localparam int unsigned CmdW     = 3;
  localparam int unsigned StatW    = 2;
  localparam int unsigned DefWidth = 32;
  localparam int unsigned STdataW  = 136;
  localparam int unsigned MTdataW  = 72;

  typedef enum logic [CmdW-1:0] {
    CMD_ADD = 3'd0,
    CMD_SUB = 3'd1,
    CMD_MUL = 3'd2,
    CMD_DIV = 3'd3,
    CMD_CMP = 3'd4
  } cmd_e;

  typedef enum logic [StatW-1:0] {
    ST_OK   = 2'd0,
    ST_OVF  = 2'd1,
    ST_DIVZ = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    MUL_X = 2'd0,
    MUL_Y = 2'd1,
    MUL_D = 2'd2,
    MUL_P = 2'd3
  } mul_sel_e;

  // controller to datapath
  typedef struct packed {
    logic     load;
    logic     mul_en;
    mul_sel_e mul_sel;
    logic     form;
    logic     gcd_step;
    logic     g_load;
    logic     div_init_n;
    logic     div_init_d;
    logic     div_step;
    logic     fin;
    logic     out_load;
  } rau_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic fast;
    logic gcd_done;
  } rau_stat_t;

endpackage

@@ rtl/rau_dp.sv @@
// datapath: operand registers, shared multiplier, binary gcd and restoring divider
module rau_dp import rau_pkg::*; #(
  parameter int unsigned WIDTH = DefWidth
) (
  input  logic               clk_i,
  input  rau_cmd_t           cmd_i,
  output rau_stat_t          stat_o,
  input  logic [STdataW-1:0] s_tdata_i,
  output logic [MTdataW-1:0] m_tdata_o
);

  localparam int unsigned DW = 2 * WIDTH;
  localparam int unsigned NW = 2 * WIDTH + 1;
  localparam int unsigned KW = $clog2(NW + 1);

  // operands
  logic [CmdW-1:0]  cmd_q;
  logic             sa_q, sb_q;
  logic [WIDTH-1:0] na_q, da_q, nb_q, db_q;
  logic [WIDTH-1:0] in_na, in_da, in_nb, in_db;

  assign in_na = s_tdata_i[4 +: WIDTH];
  assign in_da = s_tdata_i[36 +: WIDTH];
  assign in_nb = s_tdata_i[69 +: WIDTH];
  assign in_db = s_tdata_i[101 +: WIDTH];

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cmd_q <= s_tdata_i[CmdW-1:0];
      sa_q  <= s_tdata_i[3] & (in_na != '0);
      sb_q  <= s_tdata_i[68] & (in_nb != '0);
      na_q  <= in_na;
      nb_q  <= in_nb;
      da_q  <= (in_da == '0) ? WIDTH'(1) : in_da;
      db_q  <= (in_db == '0) ? WIDTH'(1) : in_db;
    end
  end

  // one shared multiplier, one product per cycle
  logic [WIDTH-1:0] mop_a, mop_b;
  logic [DW-1:0]    x_q, y_q, dd_q, p_q;

  always_comb begin
    case (cmd_i.mul_sel)
      MUL_X:   begin mop_a = na_q; mop_b = db_q; end
      MUL_Y:   begin mop_a = nb_q; mop_b = da_q; end
      MUL_D:   begin mop_a = da_q; mop_b = db_q; end
      default: begin
        mop_a = (cmd_q == CMD_DIV) ? da_q : na_q;
        mop_b = nb_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) begin
      case (cmd_i.mul_sel)
        MUL_X:   x_q  <= mop_a * mop_b;
        MUL_Y:   y_q  <= mop_a * mop_b;
        MUL_D:   dd_q <= mop_a * mop_b;
        default: p_q  <= mop_a * mop_b;
      endcase
    end
  end

  // form the unreduced fraction and the short results
  logic          sbe, xge, xeq;
  logic [NW-1:0] sum;
  logic [NW-1:0] f_n;
  logic [DW-1:0] f_d;
  logic          f_neg, f_fast, f_lt, f_eq, f_gt;
  status_e       f_st;

  always_comb begin
    sbe    = ((cmd_q == CMD_SUB) ? ~sb_q : sb_q) & (nb_q != '0);
    sum    = {1'b0, x_q} + {1'b0, y_q};
    xge    = (x_q >= y_q);
    xeq    = (x_q == y_q);
    f_n    = '0;
    f_d    = dd_q;
    f_neg  = 1'b0;
    f_fast = 1'b1;
    f_lt   = 1'b0;
    f_eq   = 1'b0;
    f_gt   = 1'b0;
    f_st   = ST_OK;
    case (cmd_q)
      CMD_ADD, CMD_SUB: begin
        f_fast = 1'b0;
        if (sa_q == sbe) begin
          f_n = sum; f_neg = sa_q;
        end else if (xge) begin
          f_n = {1'b0, x_q - y_q}; f_neg = sa_q;
        end else begin
          f_n = {1'b0, y_q - x_q}; f_neg = sbe;
        end
      end
      CMD_MUL: begin
        f_fast = 1'b0;
        f_n    = {1'b0, p_q};
        f_neg  = sa_q ^ sb_q;
      end
      CMD_DIV: begin
        if (nb_q == '0) begin
          f_st = ST_DIVZ;
        end else begin
          f_fast = 1'b0;
          f_n    = {1'b0, x_q};
          f_d    = p_q;
          f_neg  = sa_q ^ sb_q;
        end
      end
      CMD_CMP: begin
        if (sa_q != sb_q) begin
          f_lt = sa_q;
          f_gt = sb_q;
        end else begin
          f_eq = xeq;
          f_lt = sa_q ? (xge & ~xeq) : ~xge;
          f_gt = sa_q ? ~xge : (xge & ~xeq);
        end
      end
      default: f_fast = 1'b1;
    endcase
    if (f_n == '0) begin
      f_fast = 1'b1;
    end
  end

  // result staging
  logic             neg_q;
  logic [NW-1:0]    n_q;
  logic [DW-1:0]    d_q;
  logic             r_neg_q, r_lt_q, r_eq_q, r_gt_q;
  logic [DataW-1:0] r_num_q, r_den_q;
  status_e          r_st_q;
  logic             fast_q;

  // binary gcd
  logic [NW-1:0] u_q, v_q, g_q;
  logic [KW-1:0] k_q;

  // divider
  logic [NW-1:0] dvd_q, rem_q, qn_q;
  logic [NW-1:0] rem_sh;
  logic          rem_ge;
  logic          ovf;

  assign rem_sh = {rem_q[NW-2:0], dvd_q[NW-1]};
  assign rem_ge = (rem_sh >= g_q);
  assign ovf    = (qn_q[NW-1:WIDTH] != '0) || (dvd_q[NW-1:WIDTH] != '0);

  always_ff @(posedge clk_i) begin
    if (cmd_i.form) begin
      fast_q  <= f_fast;
      neg_q   <= f_neg;
      n_q     <= f_n;
      d_q     <= f_d;
      u_q     <= f_n;
      v_q     <= {1'b0, f_d};
      k_q     <= '0;
      r_neg_q <= 1'b0;
      r_num_q <= '0;
      r_den_q <= DataW'(1);
      r_lt_q  <= f_lt;
      r_eq_q  <= f_eq;
      r_gt_q  <= f_gt;
      r_st_q  <= f_st;
    end
    // one gcd step: strip twos or subtract the smaller odd value
    if (cmd_i.gcd_step && u_q != '0 && v_q != '0) begin
      if (!u_q[0] && !v_q[0]) begin
        u_q <= u_q >> 1;
        v_q <= v_q >> 1;
        k_q <= k_q + KW'(1);
      end else if (!u_q[0]) begin
        u_q <= u_q >> 1;
      end else if (!v_q[0]) begin
        v_q <= v_q >> 1;
      end else if (u_q >= v_q) begin
        u_q <= u_q - v_q;
      end else begin
        v_q <= v_q - u_q;
      end
    end
    if (cmd_i.g_load) begin
      g_q <= (u_q | v_q) << k_q;
    end
    // restoring division, one quotient bit per step
    if (cmd_i.div_init_n) begin
      dvd_q <= n_q;
      rem_q <= '0;
    end else if (cmd_i.div_init_d) begin
      qn_q  <= dvd_q;
      dvd_q <= {1'b0, d_q};
      rem_q <= '0;
    end else if (cmd_i.div_step) begin
      rem_q <= rem_ge ? (rem_sh - g_q) : rem_sh;
      dvd_q <= {dvd_q[NW-2:0], rem_ge};
    end
    if (cmd_i.fin) begin
      if (ovf) begin
        r_st_q <= ST_OVF;
      end else begin
        r_neg_q <= neg_q;
        r_num_q <= DataW'(qn_q[WIDTH-1:0]);
        r_den_q <= DataW'(dvd_q[WIDTH-1:0]);
        r_st_q  <= ST_OK;
      end
    end
  end

  assign stat_o.fast     = fast_q;
  assign stat_o.gcd_done = (u_q == '0) || (v_q == '0);

  // output register
  logic [MTdataW-1:0] m_tdata_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      m_tdata_q <= {2'b00, r_st_q, r_gt_q, r_eq_q, r_lt_q, r_den_q, r_num_q, r_neg_q};
    end
  end

  assign m_tdata_o = m_tdata_q;

endmodule

@@ rtl/rau_ctrl.sv @@
// controller: sequences load, multiply, gcd, two divisions and output
module rau_ctrl import rau_pkg::*; #(
  parameter int unsigned WIDTH = DefWidth
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      s_tvalid,
  output logic      s_tready,
  output logic      m_tvalid,
  input  logic      m_tready,
  input  rau_stat_t stat_i,
  output rau_cmd_t  cmd_o
);

  localparam int unsigned NW = 2 * WIDTH + 1;
  localparam int unsigned CW = $clog2(NW + 1);

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_MUL   = 9'b000000010,
    S_FORM  = 9'b000000100,
    S_GCD   = 9'b000001000,
    S_DIVN  = 9'b000010000,
    S_LOADD = 9'b000100000,
    S_DIVD  = 9'b001000000,
    S_FIN   = 9'b010000000,
    S_OUT   = 9'b100000000
  } state_e;

  state_e        state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          m_valid_q, m_valid_d;
  logic          out_free;

  assign out_free = ~m_valid_q | m_tready;

  // next state and commands
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    cmd_o.mul_sel = mul_sel_e'(cnt_q[1:0]);
    s_tready = 1'b0;
    case (state_q)
      S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd_o.load = 1'b1;
          cnt_d      = '0;
          state_d    = S_MUL;
        end
      end
      S_MUL: begin
        cmd_o.mul_en = 1'b1;
        cnt_d        = cnt_q + CW'(1);
        if (cnt_q == CW'(3)) begin
          state_d = S_FORM;
        end
      end
      S_FORM: begin
        cmd_o.form = 1'b1;
        state_d    = S_GCD;
      end
      S_GCD: begin
        if (stat_i.fast) begin
          state_d = S_OUT;
        end else if (stat_i.gcd_done) begin
          cmd_o.g_load     = 1'b1;
          cmd_o.div_init_n = 1'b1;
          cnt_d            = '0;
          state_d          = S_DIVN;
        end else begin
          cmd_o.gcd_step = 1'b1;
        end
      end
      S_DIVN: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + CW'(1);
        if (cnt_q == CW'(NW - 1)) begin
          state_d = S_LOADD;
        end
      end
      S_LOADD: begin
        cmd_o.div_init_d = 1'b1;
        cnt_d            = '0;
        state_d          = S_DIVD;
      end
      S_DIVD: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + CW'(1);
        if (cnt_q == CW'(NW - 1)) begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        cmd_o.fin = 1'b1;
        state_d   = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // result beat valid
  always_comb begin
    m_valid_d = m_valid_q;
    if (m_valid_q && m_tready) begin
      m_valid_d = 1'b0;
    end
    if (cmd_o.out_load) begin
      m_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      cnt_q     <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      m_valid_q <= m_valid_d;
    end
  end

  assign m_tvalid = m_valid_q;

endmodule

@@ rtl/rational_arith_unit_core.sv @@
// top level of the rational arithmetic unit
// Adds, subtracts, multiplies, divides or compares two sign-magnitude
// fractions and returns the result in lowest terms (zero as +0/1) with
// compare flags and a status (ok, overflow, divide by zero). One beat is
// taken at a time: a compare, a zero result or a divide by zero skips the
// gcd and the divisions; other operations run the binary gcd loop and
// then two bit-serial divisions by the gcd. A new beat is taken while a
// finished result still waits at the output register.
module rational_arith_unit_core import rau_pkg::*; #(
  parameter int unsigned WIDTH = DefWidth
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_tvalid,
  output logic               s_tready,
  // command[2:0] a_neg[3] a_num[35:4] a_den[67:36] b_neg[68] b_num[100:69]
  // b_den[132:101], zero fill above
  input  logic [STdataW-1:0] s_tdata,
  output logic               m_tvalid,
  input  logic               m_tready,
  // res_neg[0] res_num[32:1] res_den[64:33] less[65] equal[66] greater[67]
  // status[69:68], zero fill above
  output logic [MTdataW-1:0] m_tdata
);

  rau_cmd_t  cmd;
  rau_stat_t stat;

  // sequencer
  rau_ctrl #(
    .WIDTH(WIDTH)
  ) u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .stat_i  (stat),
    .cmd_o   (cmd)
  );

  // arithmetic
  rau_dp #(
    .WIDTH(WIDTH)
  ) u_dp (
    .clk_i    (clk_i),
    .cmd_i    (cmd),
    .stat_o   (stat),
    .s_tdata_i(s_tdata),
    .m_tdata_o(m_tdata)
  );

endmodule
